// ===== src/clx_pkg.sv =====
`default_nettype none

package clx_pkg;

  // default text length limit, offsets stop counting here
  localparam longint unsigned MAX_TEXT_LEN_DEF = 64'd65536;

  // queue depths
  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int WL_DEPTH = 5;

  // special bytes
  localparam logic [7:0] PI_LEAD  = 8'hCF;
  localparam logic [7:0] PI_TAIL  = 8'h80;
  localparam logic [7:0] SQ_LEAD  = 8'hE2;
  localparam logic [7:0] SQ_MID   = 8'h88;
  localparam logic [7:0] SQ_TAIL  = 8'h9A;

  typedef enum logic [4:0] {
    TK_NUMBER  = 5'd0,
    TK_SQRT    = 5'd1,
    TK_PLUS    = 5'd2,
    TK_MINUS   = 5'd3,
    TK_STAR    = 5'd4,
    TK_SLASH   = 5'd5,
    TK_PERCENT = 5'd6,
    TK_POWER   = 5'd7,
    TK_FACT    = 5'd8,
    TK_LPAREN  = 5'd9,
    TK_RPAREN  = 5'd10,
    TK_COMMA   = 5'd11,
    TK_EQUALS  = 5'd12,
    TK_IDENT   = 5'd13,
    TK_EXPOP   = 5'd14,
    TK_ERROR   = 5'd15,
    TK_EOF     = 5'd16
  } tok_kind_e;

  typedef enum logic [2:0] {
    CL_BLANK,
    CL_OP,
    CL_DIGIT,
    CL_ALPHA,
    CL_DOT,
    CL_OTHER
  } cls_e;

  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_NUM,
    M_NUM_DOT,
    M_NUM_E,
    M_NUM_SIGN,
    M_LEAD_DOT,
    M_PI1,
    M_SQ1,
    M_SQ2
  } mode_e;

  typedef struct packed {
    logic [7:0] data;
    cls_e       cls;
    logic       has;
    logic       eot;
  } item_t;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    case (c) inside
      8'h20, 8'h09, 8'h0D, 8'h0A: r = CL_BLANK;
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h21, 8'h28, 8'h29, 8'h2C, 8'h3D:
        r = CL_OP;
      [8'h30:8'h39]: r = CL_DIGIT;
      [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: r = CL_ALPHA;
      8'h2E: r = CL_DOT;
      default: r = CL_OTHER;
    endcase
    return r;
  endfunction

  function automatic tok_kind_e op_kind(input logic [7:0] c);
    tok_kind_e r;
    unique case (c)
      8'h2B: r = TK_PLUS;
      8'h2D: r = TK_MINUS;
      8'h2A: r = TK_STAR;
      8'h2F: r = TK_SLASH;
      8'h25: r = TK_PERCENT;
      8'h5E: r = TK_POWER;
      8'h21: r = TK_FACT;
      8'h28: r = TK_LPAREN;
      8'h29: r = TK_RPAREN;
      8'h2C: r = TK_COMMA;
      8'h3D: r = TK_EQUALS;
      default: r = TK_ERROR;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/clx_front.sv =====
`default_nettype none

module clx_front
  import clx_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF,
  localparam int PW = $clog2(MAX_TEXT_LEN + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    byte_in_i,
  input  wire logic          has_byte_i,
  input  wire logic          end_of_text_i,
  output logic               q_valid_o,
  output item_t              q_item_o,
  output logic [PW-1:0]      q_boff_o,
  output logic [PW-1:0]      q_eoff_o,
  input  wire logic          q_pop_i
);

  localparam int IPW = $clog2(IQ_DEPTH);
  localparam int ICW = $clog2(IQ_DEPTH + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_TEXT_LEN);

  item_t          item_q [IQ_DEPTH];
  logic [PW-1:0]  boff_q [IQ_DEPTH];
  logic [PW-1:0]  eoff_q [IQ_DEPTH];
  logic [IPW-1:0] wr_q, rd_q;
  logic [ICW-1:0] cnt_q;
  logic [PW-1:0]  pos_q, pos_d, pos_inc;
  logic           acc;

  assign in_stall_o = (cnt_q == ICW'(IQ_DEPTH));
  assign acc        = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = item_q[rd_q];
  assign q_boff_o   = boff_q[rd_q];
  assign q_eoff_o   = eoff_q[rd_q];

  // saturating byte position, back to zero after end of text
  assign pos_inc = (pos_q < POS_MAX) ? pos_q + PW'(1) : pos_q;
  always_comb begin
    pos_d = pos_q;
    if (acc) begin
      if (end_of_text_i) pos_d = '0;
      else if (has_byte_i) pos_d = pos_inc;
    end
  end

  // item queue storage
  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q[wr_q] <= '{data: byte_in_i, cls: classify(byte_in_i),
                        has: has_byte_i, eot: end_of_text_i};
      boff_q[wr_q] <= pos_q;
      eoff_q[wr_q] <= has_byte_i ? pos_inc : pos_q;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
      if (acc) wr_q <= (wr_q == IPW'(IQ_DEPTH - 1)) ? '0 : wr_q + IPW'(1);
      if (q_pop_i) rd_q <= (rd_q == IPW'(IQ_DEPTH - 1)) ? '0 : rd_q + IPW'(1);
      cnt_q <= cnt_q + ICW'(acc) - ICW'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== src/clx_core.sv =====
`default_nettype none

module clx_core
  import clx_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF,
  localparam int PW = $clog2(MAX_TEXT_LEN + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  item_t              in_item_i,
  input  wire logic [PW-1:0] in_boff_i,
  input  wire logic [PW-1:0] in_eoff_i,
  output logic               in_pop_o,
  input  wire logic          out_full_i,
  output logic               push_o,
  output token_t             push_tok_o
);

  localparam int WLW = $clog2(WL_DEPTH + 1);
  localparam int WIW = $clog2(WL_DEPTH);

  // pending symbol list: replayed lookahead, item byte, end mark
  logic [7:0]     wl_byte_q [WL_DEPTH];
  cls_e           wl_cls_q  [WL_DEPTH];
  logic [PW-1:0]  wl_off_q  [WL_DEPTH];
  logic           wl_end_q  [WL_DEPTH];
  logic [WLW-1:0] wl_len_q;

  logic [7:0]     e_byte [WL_DEPTH];
  cls_e           e_cls  [WL_DEPTH];
  logic [PW-1:0]  e_off  [WL_DEPTH];
  logic           e_end  [WL_DEPTH];
  logic [WLW-1:0] e_len;

  logic [7:0]     n_byte [WL_DEPTH];
  cls_e           n_cls  [WL_DEPTH];
  logic [PW-1:0]  n_off  [WL_DEPTH];
  logic           n_end  [WL_DEPTH];
  logic [WLW-1:0] n_len;

  // scanner state
  mode_e         mode_q, mode_d;
  logic [PW-1:0] tb_q, tb_d;
  logic [7:0]    la_q [3];
  logic [7:0]    la_d [3];
  logic [1:0]    la_cnt_q, la_cnt_d;
  logic          seen_q, seen_d;
  logic          xp_q, xp_d;
  logic [7:0]    pre_q [3];
  logic          pre_we;
  logic [1:0]    pre_idx;

  // token hold stage, tags the last word of an item
  token_t hold_q, tok;
  logic   hold_v_q, hold_fin_q;

  logic          go, pop, step, done, cons, rb, em, clr;
  tok_kind_e     kind;
  logic [PW-1:0] ts, tl, idlen, cut;
  logic [7:0]    c;
  cls_e          cl;
  logic [PW-1:0] off;
  logic [WLW:0]  sum_len;
  logic [2:0]    j;

  function automatic logic [PW-1:0] span(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (b > a) ? b - a : '0;
  endfunction

  function automatic logic [15:0] sat16(input logic [PW-1:0] v);
    return (v > 32'd65535) ? 16'hFFFF : 16'(v);
  endfunction

  assign go       = !out_full_i;
  assign pop      = go && (wl_len_q == '0) && in_valid_i;
  assign in_pop_o = pop;

  // effective list: held symbols or the fresh item
  always_comb begin
    for (int i = 0; i < WL_DEPTH; i++) begin
      e_byte[i] = wl_byte_q[i];
      e_cls[i]  = wl_cls_q[i];
      e_off[i]  = wl_off_q[i];
      e_end[i]  = wl_end_q[i];
    end
    e_len = wl_len_q;
    if (wl_len_q == '0) begin
      e_len = WLW'(in_valid_i ? (32'(in_item_i.has) + 32'(in_item_i.eot)) : 32'd0);
      if (in_item_i.has) begin
        e_byte[0] = in_item_i.data;
        e_cls[0]  = in_item_i.cls;
        e_off[0]  = in_boff_i;
        e_end[0]  = 1'b0;
        e_byte[1] = 8'h00;
        e_cls[1]  = CL_OTHER;
        e_off[1]  = in_eoff_i;
        e_end[1]  = 1'b1;
      end else begin
        e_byte[0] = 8'h00;
        e_cls[0]  = CL_OTHER;
        e_off[0]  = in_eoff_i;
        e_end[0]  = 1'b1;
      end
    end
  end

  assign step = go && (e_len != '0);
  assign c    = e_byte[0];
  assign cl   = e_cls[0];
  assign off  = e_off[0];

  assign idlen = span(tb_q, off);
  assign cut   = (off >= PW'(la_cnt_q)) ? off - PW'(la_cnt_q) : '0;

  // one scanner step on the head symbol
  always_comb begin
    mode_d   = mode_q;
    tb_d     = tb_q;
    la_d     = la_q;
    la_cnt_d = la_cnt_q;
    seen_d   = seen_q;
    xp_d     = xp_q;
    pre_we   = 1'b0;
    pre_idx  = 2'd0;
    cons     = 1'b0;
    rb       = 1'b0;
    em       = 1'b0;
    clr      = 1'b0;
    kind     = TK_ERROR;
    ts       = tb_q;
    tl       = PW'(1);
    unique case (mode_q)
      M_IDLE: begin
        cons = 1'b1;
        if (e_end[0]) begin
          em   = 1'b1;
          kind = TK_EOF;
          ts   = off;
          tl   = '0;
          clr  = 1'b1;
        end else if (cl != CL_BLANK) begin
          tb_d     = off;
          la_cnt_d = 2'd0;
          ts       = off;
          if (cl == CL_OP) begin
            em   = 1'b1;
            kind = op_kind(c);
          end else if (c == PI_LEAD) begin
            mode_d = M_PI1;
          end else if (c == SQ_LEAD) begin
            mode_d = M_SQ1;
          end else if (cl == CL_ALPHA) begin
            mode_d = M_IDENT;
            xp_d   = 1'b0;
            pre_we = 1'b1;
          end else if (cl == CL_DIGIT) begin
            mode_d = M_NUM;
            seen_d = 1'b0;
          end else if (cl == CL_DOT) begin
            mode_d = M_LEAD_DOT;
          end else begin
            em   = 1'b1;
            kind = TK_ERROR;
          end
        end
      end
      M_IDENT: begin
        if (xp_q) begin
          if (c == 8'h20 || c == 8'h09) begin
            cons = 1'b1;
          end else begin
            xp_d   = 1'b0;
            mode_d = M_IDLE;
            em     = 1'b1;
            kind   = (c == 8'h28) ? TK_IDENT : TK_EXPOP;
            tl     = PW'(3);
          end
        end else if (cl == CL_ALPHA || cl == CL_DIGIT) begin
          cons = 1'b1;
          if (idlen < PW'(3)) begin
            pre_we  = 1'b1;
            pre_idx = idlen[1:0];
          end
        end else if (idlen == PW'(3) && (pre_q[0] | 8'h20) == 8'h65
                     && (pre_q[1] | 8'h20) == 8'h78 && (pre_q[2] | 8'h20) == 8'h70) begin
          xp_d = 1'b1;
        end else begin
          em     = 1'b1;
          kind   = TK_IDENT;
          tl     = idlen;
          mode_d = M_IDLE;
        end
      end
      M_NUM: begin
        if (cl == CL_DIGIT) begin
          cons = 1'b1;
        end else if ((cl == CL_DOT && !seen_q) || c == 8'h65 || c == 8'h45) begin
          cons   = 1'b1;
          mode_d = (cl == CL_DOT) ? M_NUM_DOT : M_NUM_E;
          if (la_cnt_q != 2'd3) begin
            la_d[la_cnt_q] = c;
            la_cnt_d       = la_cnt_q + 2'd1;
          end
        end else begin
          em     = 1'b1;
          kind   = TK_NUMBER;
          tl     = idlen;
          mode_d = M_IDLE;
        end
      end
      M_NUM_DOT, M_NUM_SIGN, M_NUM_E: begin
        if (cl == CL_DIGIT) begin
          cons     = 1'b1;
          if (mode_q == M_NUM_DOT) seen_d = 1'b1;
          la_cnt_d = 2'd0;
          mode_d   = M_NUM;
        end else if (mode_q == M_NUM_E && (c == 8'h2B || c == 8'h2D)) begin
          cons   = 1'b1;
          mode_d = M_NUM_SIGN;
          if (la_cnt_q != 2'd3) begin
            la_d[la_cnt_q] = c;
            la_cnt_d       = la_cnt_q + 2'd1;
          end
        end else begin
          em       = 1'b1;
          kind     = TK_NUMBER;
          tl       = span(tb_q, cut);
          mode_d   = M_IDLE;
          rb       = 1'b1;
          la_cnt_d = 2'd0;
        end
      end
      M_LEAD_DOT: begin
        if (cl == CL_DIGIT) begin
          cons   = 1'b1;
          seen_d = 1'b1;
          mode_d = M_NUM;
        end else begin
          em     = 1'b1;
          mode_d = M_IDLE;
        end
      end
      M_PI1: begin
        mode_d = M_IDLE;
        em     = 1'b1;
        if (c == PI_TAIL) begin
          cons = 1'b1;
          kind = TK_NUMBER;
          tl   = PW'(2);
        end
      end
      M_SQ1: begin
        if (c == SQ_MID) begin
          cons   = 1'b1;
          mode_d = M_SQ2;
          if (la_cnt_q != 2'd3) begin
            la_d[la_cnt_q] = c;
            la_cnt_d       = la_cnt_q + 2'd1;
          end
        end else begin
          em     = 1'b1;
          mode_d = M_IDLE;
        end
      end
      M_SQ2: begin
        mode_d   = M_IDLE;
        em       = 1'b1;
        la_cnt_d = 2'd0;
        if (c == SQ_TAIL) begin
          cons = 1'b1;
          kind = TK_SQRT;
          tl   = PW'(3);
        end else begin
          rb = 1'b1;
        end
      end
      default: begin
        mode_d = M_IDLE;
      end
    endcase
    // end of text returns everything to the start of a new text
    if (clr) begin
      mode_d   = M_IDLE;
      tb_d     = '0;
      la_cnt_d = 2'd0;
      seen_d   = 1'b0;
      xp_d     = 1'b0;
    end
  end

  // next symbol list
  always_comb begin
    sum_len = '0;
    j       = '0;
    for (int i = 0; i < WL_DEPTH; i++) begin
      n_byte[i] = e_byte[i];
      n_cls[i]  = e_cls[i];
      n_off[i]  = e_off[i];
      n_end[i]  = e_end[i];
    end
    n_len = e_len;
    if (cons) begin
      for (int i = 0; i < WL_DEPTH - 1; i++) begin
        n_byte[i] = e_byte[i + 1];
        n_cls[i]  = e_cls[i + 1];
        n_off[i]  = e_off[i + 1];
        n_end[i]  = e_end[i + 1];
      end
      n_len = e_len - WLW'(1);
    end else if (rb) begin
      // held lookahead goes in front of the unconsumed symbols
      for (int i = 0; i < WL_DEPTH; i++) begin
        if (3'(i) < {1'b0, la_cnt_q}) begin
          n_byte[i] = la_q[i[1:0]];
          n_cls[i]  = classify(la_q[i[1:0]]);
          n_off[i]  = (off >= PW'({1'b0, la_cnt_q} - 3'(i)))
                      ? off - PW'({1'b0, la_cnt_q} - 3'(i)) : '0;
          n_end[i]  = 1'b0;
        end else begin
          j         = 3'(i) - {1'b0, la_cnt_q};
          n_byte[i] = e_byte[j[WIW-1:0]];
          n_cls[i]  = e_cls[j[WIW-1:0]];
          n_off[i]  = e_off[j[WIW-1:0]];
          n_end[i]  = e_end[j[WIW-1:0]];
        end
      end
      sum_len = {1'b0, e_len} + (WLW + 1)'(la_cnt_q);
      n_len   = (sum_len > (WLW + 1)'(WL_DEPTH)) ? WLW'(WL_DEPTH) : sum_len[WLW-1:0];
    end
  end

  // token formed this step, item completion
  assign tok  = '{kind: kind, start: sat16(ts), len: sat16(tl), last: 1'b0};
  assign done = step ? (n_len == '0) : pop;

  always_comb begin
    push_o          = go && hold_v_q && (hold_fin_q || (step && em) || done);
    push_tok_o      = hold_q;
    push_tok_o.last = hold_fin_q || (done && !(step && em));
  end

  // symbol list and ident prefix, payload only
  always_ff @(posedge clk_i) begin
    if (step) begin
      wl_byte_q <= n_byte;
      wl_cls_q  <= n_cls;
      wl_off_q  <= n_off;
      wl_end_q  <= n_end;
      la_q      <= la_d;
      if (pre_we) pre_q[pre_idx] <= c;
    end
    if (step && em) hold_q <= tok;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_len_q   <= '0;
      mode_q     <= M_IDLE;
      tb_q       <= '0;
      la_cnt_q   <= 2'd0;
      seen_q     <= 1'b0;
      xp_q       <= 1'b0;
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
    end else begin
      if (step) begin
        wl_len_q <= n_len;
        mode_q   <= mode_d;
        tb_q     <= tb_d;
        la_cnt_q <= la_cnt_d;
        seen_q   <= seen_d;
        xp_q     <= xp_d;
      end
      if (step && em) begin
        hold_v_q   <= 1'b1;
        hold_fin_q <= done;
      end else if (push_o) begin
        hold_v_q   <= 1'b0;
        hold_fin_q <= 1'b0;
      end
    end
  end

  // the final flag is only set while a word is held
  a_fin_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_fin_q |-> hold_v_q)
    else $error("final flag without held word");

  // end mark leaves the scanner fresh
  a_eot_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && clr) |=> (mode_q == M_IDLE && la_cnt_q == 2'd0 && tb_q == '0))
    else $error("state not cleared after end of text");

  // no new item while symbols remain
  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (wl_len_q == '0))
    else $error("item taken while symbols pending");

  // list never overflows
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_len_q <= WLW'(WL_DEPTH))
    else $error("symbol list overflow");

endmodule

`default_nettype wire

// ===== src/clx_outq.sv =====
`default_nettype none

module clx_outq
  import clx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  token_t    push_tok_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output token_t    out_tok_o
);

  localparam int OPW = $clog2(OQ_DEPTH);
  localparam int OCW = $clog2(OQ_DEPTH + 1);

  token_t         mem_q [OQ_DEPTH];
  logic [OPW-1:0] wr_q, rd_q;
  logic [OCW-1:0] cnt_q;
  logic           pop;

  assign full_o      = (cnt_q == OCW'(OQ_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_tok_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == OPW'(OQ_DEPTH - 1)) ? '0 : wr_q + OPW'(1);
      if (pop) rd_q <= (rd_q == OPW'(OQ_DEPTH - 1)) ? '0 : rd_q + OPW'(1);
      cnt_q <= cnt_q + OCW'(push_i) - OCW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/calculator_expression_lexer.sv =====
// Streaming expression lexer: one source byte per input word, tokens out.
// Input channel: in_valid_i / in_stall_o with byte_in_i, has_byte_i and
// end_of_text_i. A word with has_byte_i low and end_of_text_i high only
// closes the text; a word with both low does nothing.
// Output channel: out_valid_o / out_stall_i with token_kind_o,
// token_start_o, token_length_o and last_token_o, the latter set on the
// last token a given input word causes.
// Throughput: one byte per cycle through the scanner while the output
// queue is not full. A byte that closes the token before it is itself
// scanned again, a word with both a byte and end of text has its end mark
// scanned after the byte, and after a failed lookahead (number dot or
// exponent, partial square-root symbol) the held bytes are rescanned.
// Latency: an accepted word passes the input queue, the scanner step into
// the hold stage that tags the last word, and the output queue before
// out_valid_o rises; each extra scanner step for the word delays it more.
// Reset clears all control state; the next word starts a new text at offset 0.
// End of text emits eof and also returns the block to that start state.
// When the receiver stalls, the 4-word output queue fills, the scanner
// stops, and the 2-word input queue raises in_stall_o.
`default_nettype none

module calculator_expression_lexer
  import clx_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        has_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       token_kind_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic             last_token_o
);

  localparam int PW = $clog2(MAX_TEXT_LEN + 1);

  logic          q_valid, q_pop, oq_full, push;
  item_t         q_item;
  logic [PW-1:0] q_boff, q_eoff;
  token_t        push_tok, out_tok;

  clx_front #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .has_byte_i    (has_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_boff_o      (q_boff),
    .q_eoff_o      (q_eoff),
    .q_pop_i       (q_pop)
  );

  clx_core #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_item_i  (q_item),
    .in_boff_i  (q_boff),
    .in_eoff_i  (q_eoff),
    .in_pop_o   (q_pop),
    .out_full_i (oq_full),
    .push_o     (push),
    .push_tok_o (push_tok)
  );

  clx_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_tok_i  (push_tok),
    .full_o      (oq_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tok_o   (out_tok)
  );

  assign token_kind_o   = out_tok.kind;
  assign token_start_o  = out_tok.start;
  assign token_length_o = out_tok.len;
  assign last_token_o   = out_tok.last;

endmodule

`default_nettype wire
